FILE: rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pfr_pkg.sv
package pfr_pkg;

    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 16;
    localparam int STAMP_W        = 32;
    localparam int FAULT_W        = 32;
    localparam int CFG_W          = 4;

    localparam logic [CFG_W-1:0] FRAMES_RST = 4'd8;

    typedef enum logic {
        CFG_POLICY = 1'b0,
        CFG_FRAMES = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_ACCESS  = 1'b0,
        OP_RESTART = 1'b1
    } t_op;

    typedef enum logic {
        POL_FIFO = 1'b0,
        POL_LRU  = 1'b1
    } t_policy;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

endpackage

FILE: rtl/pfr_ram.sv
module pfr_ram import pfr_pkg::*; #(
    parameter int WIDTH = PAGE_BITS_DEF,
    parameter int DEPTH = MAX_FRAMES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/page_frame_replacement_top.sv
// Page frame replacement unit: a fully associative set of page frames.
// Input channel (i_in_valid / o_in_stall) carries one item: i_op selects an
// access of page i_page or a restart. Output channel (o_out_valid /
// i_out_stall) returns exactly one result per item: hit or fault, the frame
// used, any evicted page, the occupancy and the saturating fault total.
// Configuration (i_cfg_valid / o_cfg_ready, always ready) sets the policy
// (FIFO or least recently used) and the frame count; write it only while idle
// and follow it with a restart.
// Sequence: an access walks the occupied frames through one read port of the
// page and stamp memories, one frame per cycle, and then commits in the update
// state; a restart goes straight to the update state. A new item is accepted
// only once the unit is back in idle. The result sits in an output register,
// so a stalled receiver holds the update state only once a second result is
// ready; the unit then waits.
// Reset empties the frames (occupancy zero), clears the FIFO pointer, the
// request index and the fault count, and sets FIFO with eight frames. The
// memories need no clearing: an entry is only read after it was written.
module page_frame_replacement_top import pfr_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    localparam int SLOT_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    localparam int OCC_W     = $clog2(MAX_FRAMES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_op,
    input  logic [PAGE_BITS-1:0] i_page,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_hit,
    output logic                 o_fault,
    output logic [SLOT_W-1:0]    o_slot,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [OCC_W-1:0]     o_occupied,
    output logic [FAULT_W-1:0]   o_fault_total
);

    `include "assert_macros.svh"

    // configuration registers
    logic             r_policy;
    logic [CFG_W-1:0] r_frames;

    // control state
    t_state               r_state;
    logic [OCC_W-1:0]     r_occ;
    logic [SLOT_W-1:0]    r_ptr;
    logic [STAMP_W-1:0]   r_req;
    logic [FAULT_W-1:0]   r_faults;

    // item being worked on
    logic                 r_op;
    logic [PAGE_BITS-1:0] r_page;

    // scan state
    logic [OCC_W-1:0]     r_rd_idx;
    logic                 r_cmp_vld;
    logic [SLOT_W-1:0]    r_cmp_idx;
    logic                 r_found;
    logic [SLOT_W-1:0]    r_hit_slot;
    logic [SLOT_W-1:0]    r_best_slot;
    logic [STAMP_W-1:0]   r_best_age;
    logic [PAGE_BITS-1:0] r_best_page;
    logic [PAGE_BITS-1:0] r_fifo_page;

    // output register
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic                 r_out_fault;
    logic [SLOT_W-1:0]    r_out_slot;
    logic                 r_out_ev_valid;
    logic [PAGE_BITS-1:0] r_out_ev_page;
    logic [OCC_W-1:0]     r_out_occ;
    logic [FAULT_W-1:0]   r_out_faults;

    // memory ports
    logic                 w_rd_en;
    logic [PAGE_BITS-1:0] w_page_q;
    logic [STAMP_W-1:0]   w_stamp_q;
    logic                 w_fr_we;
    logic                 w_st_we;

    // derived values
    logic [OCC_W-1:0]     w_limit;
    logic [SLOT_W-1:0]    w_fifo_slot;
    logic [STAMP_W-1:0]   w_age;
    logic                 w_accept;
    logic                 w_commit;

    // commit decisions
    logic                 n_hit;
    logic                 n_fault;
    logic [SLOT_W-1:0]    n_slot;
    logic                 n_ev_valid;
    logic [PAGE_BITS-1:0] n_ev_page;
    logic [OCC_W-1:0]     n_occ;
    logic [SLOT_W-1:0]    n_ptr;
    logic [FAULT_W-1:0]   n_faults;
    logic [OCC_W-1:0]     w_slot_inc;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_commit    = (r_state == S_UPDATE) && (!r_out_valid || !i_out_stall);

    // Frame count in force: zero acts as one, anything above the set as the set.
    always_comb begin
        if (r_frames == '0) begin
            w_limit = OCC_W'(1);
        end else if (32'(r_frames) > MAX_FRAMES) begin
            w_limit = OCC_W'(MAX_FRAMES);
        end else begin
            w_limit = OCC_W'(r_frames);
        end
    end

    // A stale pointer beyond the frame count restarts at frame zero.
    assign w_fifo_slot = (OCC_W'(r_ptr) < w_limit) ? r_ptr : '0;
    assign w_age       = r_req - w_stamp_q;

    // One frame per cycle below the occupancy; both memories share the address.
    assign w_rd_en = (r_state == S_SCAN) && (r_rd_idx < r_occ);

    pfr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (w_fr_we),
        .i_waddr (n_slot),
        .i_wdata (r_page),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_idx[SLOT_W-1:0]),
        .o_rdata (w_page_q)
    );

    pfr_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (MAX_FRAMES)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (n_slot),
        .i_wdata (r_req),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_idx[SLOT_W-1:0]),
        .o_rdata (w_stamp_q)
    );

    // Resolve the item once the scan is done.
    always_comb begin
        n_hit      = 1'b0;
        n_fault    = 1'b0;
        n_slot     = '0;
        n_ev_valid = 1'b0;
        n_ev_page  = '0;
        n_occ      = r_occ;
        n_ptr      = r_ptr;
        n_faults   = r_faults;
        w_slot_inc = '0;
        if (r_op == OP_RESTART) begin
            n_occ    = '0;
            n_ptr    = '0;
            n_faults = '0;
        end else if (r_found) begin
            n_hit  = 1'b1;
            n_slot = r_hit_slot;
        end else begin
            n_fault = 1'b1;
            if (r_faults != '1) begin
                n_faults = r_faults + FAULT_W'(1);
            end
            if (r_occ < w_limit) begin
                // fill the next empty frame
                n_slot = r_occ[SLOT_W-1:0];
                n_occ  = r_occ + OCC_W'(1);
            end else if (r_policy == POL_FIFO) begin
                n_slot     = w_fifo_slot;
                n_ev_valid = 1'b1;
                n_ev_page  = r_fifo_page;
            end else begin
                n_slot     = r_best_slot;
                n_ev_valid = 1'b1;
                n_ev_page  = r_best_page;
            end
            w_slot_inc = OCC_W'(n_slot) + OCC_W'(1);
            if (r_policy == POL_FIFO) begin
                n_ptr = (w_slot_inc >= w_limit) ? '0 : w_slot_inc[SLOT_W-1:0];
            end
        end
    end

    assign w_fr_we = w_commit && (r_op == OP_ACCESS) && !r_found;
    assign w_st_we = w_commit && (r_op == OP_ACCESS);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FIFO;
            r_frames <= FRAMES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_POLICY: r_policy <= i_cfg_data[0];
                CFG_FRAMES: r_frames <= i_cfg_data;
                default:    r_policy <= r_policy;
            endcase
        end
    end

    // Sequencer and persistent counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_ptr     <= '0;
            r_req     <= '0;
            r_faults  <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_rd_idx  <= '0;
                        r_cmp_vld <= 1'b0;
                        r_found   <= 1'b0;
                        r_state   <= (i_op == OP_RESTART) ? S_UPDATE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= w_rd_en;
                    r_cmp_idx <= r_rd_idx[SLOT_W-1:0];
                    if (w_rd_en) begin
                        r_rd_idx <= r_rd_idx + OCC_W'(1);
                    end
                    // the compare still in flight lands at this same edge
                    if (r_rd_idx >= r_occ) begin
                        r_state <= S_UPDATE;
                    end
                    if (r_cmp_vld && !r_found && (w_page_q == r_page)) begin
                        r_found    <= 1'b1;
                        r_hit_slot <= r_cmp_idx;
                    end
                end
                S_UPDATE: begin
                    if (w_commit) begin
                        r_occ    <= n_occ;
                        r_ptr    <= n_ptr;
                        r_faults <= n_faults;
                        r_req    <= (r_op == OP_RESTART) ? '0 : r_req + STAMP_W'(1);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item payload and victim tracking; no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_op;
            r_page <= i_page;
        end
        if ((r_state == S_SCAN) && r_cmp_vld) begin
            // oldest stamp among the frames in force, lowest frame on a tie
            if ((OCC_W'(r_cmp_idx) < w_limit) &&
                ((r_cmp_idx == '0) || (w_age > r_best_age))) begin
                r_best_slot <= r_cmp_idx;
                r_best_age  <= w_age;
                r_best_page <= w_page_q;
            end
            if (r_cmp_idx == w_fifo_slot) begin
                r_fifo_page <= w_page_q;
            end
        end
    end

    // Output register: hold while stalled, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_hit      <= n_hit;
            r_out_fault    <= n_fault;
            r_out_slot     <= n_slot;
            r_out_ev_valid <= n_ev_valid;
            r_out_ev_page  <= n_ev_page;
            r_out_occ      <= n_occ;
            r_out_faults   <= n_faults;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_fault         = r_out_fault;
    assign o_slot          = r_out_slot;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_occupied      = r_out_occ;
    assign o_fault_total   = r_out_faults;

    `ASSERT_IMPLIES(a_hit_xor_fault, i_clk, i_rst_n, r_out_valid, !(r_out_hit && r_out_fault), "hit and fault together")
    `ASSERT_IMPLIES(a_evict_needs_fault, i_clk, i_rst_n, r_out_valid && r_out_ev_valid, r_out_fault && (r_out_occ == r_occ), "eviction without a fault in a full set")
    `ASSERT_NEXT(a_fault_mono, i_clk, i_rst_n, w_commit && (r_op == OP_ACCESS), r_faults >= $past(r_faults), "fault total went down on an access")
    `ASSERT_ALWAYS(a_occ_bound, i_clk, i_rst_n, 32'(r_occ) <= MAX_FRAMES, "occupancy beyond the frame set")

endmodule
